[rtl/core/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the searchable deque
// Operation and status codes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int DATA_W          = 32;
  localparam int KIND_W          = 3;
  localparam int CNT_OUT_W       = 7;
  localparam int RES_W           = 11;  // status + found + count + empty
  localparam int OUT_W           = 16;  // result padded to whole bytes

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_DROP_FRONT = 3'd2,
    KIND_DROP_BACK  = 3'd3,
    KIND_SEARCH     = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_OP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch incoming transaction
    logic srch_step;  // issue next search read / compare
    logic found_set;  // search matched
    logic commit;     // apply operation and load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_search;  // incoming transaction is a search
    logic empty;      // no entries held
    logic hit;        // compared entry equals key
    logic miss;       // all held entries compared without a match
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

[rtl/core/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl: operation sequencer
// Takes one transaction at a time, runs the search walk for a search of a held list, then commits.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output deq_pkg::cmd_t cmd,
  input  deq_pkg::sts_t sts
);

  deq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      deq_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          // searching an empty list needs no walk
          if (sts.in_search && !sts.empty) begin
            state_next = deq_pkg::ST_SEARCH;
          end else begin
            state_next = deq_pkg::ST_OP;
          end
        end
      end
      deq_pkg::ST_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (sts.hit) begin
          cmd.found_set = 1'b1;
          state_next    = deq_pkg::ST_OP;
        end else if (sts.miss) begin
          state_next = deq_pkg::ST_OP;
        end
      end
      deq_pkg::ST_OP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/deq_dp.sv]
// ----------------------------------------------------------------------------
// deq_dp: ring store datapath
// Entry memory, front pointer, count, search walker and result register.
// ----------------------------------------------------------------------------
module deq_dp #(
  parameter int MAX_ENTRIES = deq_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [deq_pkg::KIND_W-1:0]        s_tuser,
  input  logic signed [deq_pkg::DATA_W-1:0] s_tdata,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [deq_pkg::OUT_W-1:0]         m_tdata,
  input  deq_pkg::cmd_t                     cmd,
  output deq_pkg::sts_t                     sts
);

  localparam int PW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > deq_pkg::CNT_OUT_W) ? CW : deq_pkg::CNT_OUT_W;
  localparam logic [PW:0]   MAX_EXT  = (PW+1)'(MAX_ENTRIES);
  localparam logic [PW-1:0] LAST_IDX = PW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);
  localparam int PAD_W = deq_pkg::OUT_W - deq_pkg::RES_W;

  logic signed [deq_pkg::DATA_W-1:0] mem [MAX_ENTRIES];

  deq_pkg::kind_t                    kind;
  logic signed [deq_pkg::DATA_W-1:0] key;
  logic [PW-1:0]                     front;
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     idx;
  logic                              rd_vld;
  logic signed [deq_pkg::DATA_W-1:0] rd_data;
  logic                              found;

  logic [PW-1:0]    off;
  logic [PW:0]      sum;
  logic [PW-1:0]    slot;
  logic [PW-1:0]    front_dec;
  logic             full;
  logic             issue;
  logic [PW-1:0]    front_next;
  logic [CW-1:0]    count_next;
  deq_pkg::status_t status;
  logic             wr_en;
  logic [PW-1:0]    wr_addr;
  logic [XW-1:0]    cnt_x;

  // shared ring adder: front + offset, wrapped once
  always_comb begin
    priority if (cmd.srch_step) begin
      off = idx[PW-1:0];
    end else if (kind == deq_pkg::KIND_PUSH_BACK) begin
      off = count[PW-1:0];
    end else begin
      off = PW'(1);
    end
  end

  assign sum       = {1'b0, front} + {1'b0, off};
  assign slot      = (sum >= MAX_EXT) ? PW'(sum - MAX_EXT) : sum[PW-1:0];
  assign front_dec = (front == '0) ? LAST_IDX : front - 1'b1;
  assign full      = (count == FULL_CNT);

  always_comb begin
    front_next = front;
    count_next = count;
    status     = deq_pkg::STAT_DONE;
    wr_en      = 1'b0;
    wr_addr    = slot;
    unique case (kind)
      deq_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          status = deq_pkg::STAT_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          status = deq_pkg::STAT_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::KIND_DROP_FRONT: begin
        if (count == '0) begin
          status = deq_pkg::STAT_EMPTY;
        end else begin
          front_next = slot;
          count_next = count - 1'b1;
        end
      end
      deq_pkg::KIND_DROP_BACK: begin
        if (count == '0) begin
          status = deq_pkg::STAT_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      deq_pkg::KIND_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign issue = cmd.srch_step && (idx != count);
  assign cnt_x = XW'(count_next);

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= key;
    end
    rd_data <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rd_vld <= 1'b0;
      end else begin
        rd_vld <= issue;
      end
      if (cmd.commit) begin
        front    <= front_next;
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind  <= deq_pkg::kind_t'(s_tuser);
      key   <= s_tdata;
      idx   <= '0;
      found <= 1'b0;
    end else begin
      if (issue) begin
        idx <= idx + 1'b1;
      end
      if (cmd.found_set) begin
        found <= 1'b1;
      end
    end
    if (cmd.commit) begin
      m_tdata <= {{PAD_W{1'b0}}, (count_next == '0), cnt_x[deq_pkg::CNT_OUT_W-1:0],
                  found, status};
    end
  end

  assign sts.in_search = (s_tuser == deq_pkg::KIND_SEARCH);
  assign sts.empty     = (count == '0);
  assign sts.hit       = rd_vld && (rd_data == key);
  assign sts.miss      = !rd_vld && (idx == count);
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

[rtl/core/double_ended_queue_with_search.sv]
// Push, drop, clear, unused codes and an empty-list search go from accept straight
// to the commit state. Search of a held list first walks the entries: one registered
// memory read per entry, compared in the next cycle; a match or a full miss ends it.
// Throughput: one transaction in flight; a new one is taken the cycle after
// the result is loaded, while that result may still wait on the master side.
// Reset (rst, synchronous, high) empties the list; stored entries are not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_with_search: bounded deque with membership search
// Signed 32-bit entries in a ring store addressed by front pointer and count.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search #(
  parameter int MAX_ENTRIES = deq_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // slave side: operation requests
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic signed [deq_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
  input  logic [deq_pkg::KIND_W-1:0]        s_tuser,   // [2:0] kind
  // master side: results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [1:0] status, [2] found, [9:3] entry_count, [10] is_empty, [15:11] zero
  output logic [deq_pkg::OUT_W-1:0]         m_tdata
);

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;

  // sequencer: accept, search walk, commit
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // store, pointers and result register
  deq_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

`ifndef SYNTHESIS
  // one transaction at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("deque accepted back-to-back transactions");

  // a match is only reported with a done status
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == deq_pkg::STAT_DONE))
    else $error("found flag with non-done status");

  // an empty refusal leaves the list empty
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == deq_pkg::STAT_EMPTY)) |-> m_tdata[10])
    else $error("empty status without empty flag");

  // a new result is loaded only when the result register is free
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> !$past(cmd.commit))
    else $error("result overwritten while stalled");
`endif

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for double_ended_queue_with_search
// Every accepted request is run through a behavioral deque that tracks the
// ring store, front index and count and queues the reply it predicts. Each
// reply on the master side is checked field by field against the oldest
// queued prediction. A short directed pass covers the corner cases. Random
// phases then push toward full, drain toward empty, or mix searches and
// clears. Both sides stall in random bursts, and the tail runs without stalls.
// ----------------------------------------------------------------------------

// Behavioral copy of the deque. Predicts one reply per request and
// checks the replies in order.
class deque_tracker;
  localparam int DEPTH = deq_pkg::MAX_ENTRIES_DEF;

  typedef struct packed {
    deq_pkg::status_t status;
    logic             found;
    logic [6:0]       count;
    logic             is_empty;
  } reply_t;

  logic [31:0] slots [DEPTH];
  int unsigned head;
  int unsigned held;
  reply_t      due [$];
  int unsigned failures;

  function new();
    head     = 0;
    held     = 0;
    failures = 0;
  endfunction

  function int unsigned entries();
    return held;
  endfunction

  function int unsigned pending();
    return due.size();
  endfunction

  // i counts from the front entry
  function logic [31:0] entry_at(int unsigned i);
    return slots[(head + i) % DEPTH];
  endfunction

  function void note_request(logic [2:0] op, logic [31:0] key);
    reply_t r;
    int unsigned i;
    r.status = deq_pkg::STAT_DONE;
    r.found  = 1'b0;
    case (op)
      deq_pkg::KIND_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          r.status = deq_pkg::STAT_FULL;
        end else begin
          head        = (head == 0) ? DEPTH - 1 : head - 1;
          slots[head] = key;
          held++;
        end
      end
      deq_pkg::KIND_PUSH_BACK: begin
        if (held >= DEPTH) begin
          r.status = deq_pkg::STAT_FULL;
        end else begin
          slots[(head + held) % DEPTH] = key;
          held++;
        end
      end
      deq_pkg::KIND_DROP_FRONT: begin
        if (held == 0) begin
          r.status = deq_pkg::STAT_EMPTY;
        end else begin
          head = (head + 1) % DEPTH;
          held--;
        end
      end
      deq_pkg::KIND_DROP_BACK: begin
        if (held == 0) r.status = deq_pkg::STAT_EMPTY;
        else held--;
      end
      deq_pkg::KIND_SEARCH: begin
        for (i = 0; i < held; i++) begin
          if (slots[(head + i) % DEPTH] == key) begin
            r.found = 1'b1;
            break;
          end
        end
      end
      deq_pkg::KIND_CLEAR: begin
        head = 0;
        held = 0;
      end
      default: ;
    endcase
    r.count    = 7'(held);
    r.is_empty = (held == 0);
    due.push_back(r);
  endfunction

  function void field_check(string fld, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", fld, want, got);
      failures++;
    end
  endfunction

  function void check_reply(logic [15:0] word);
    reply_t want;
    if (due.size() == 0) begin
      $error("reply with no request pending: tdata %h", word);
      failures++;
      return;
    end
    want = due.pop_front();
    field_check("status", 7'(want.status), 7'(word[1:0]));
    field_check("found", 7'(want.found), 7'(word[2]));
    field_check("entry_count", want.count, word[9:3]);
    field_check("is_empty", 7'(want.is_empty), 7'(word[10]));
    field_check("padding", 7'd0, 7'(word[15:11]));
  endfunction
endclass

module tb_top;

  // Watchdog: cycles without any transaction on either side. The limit is
  // many times the slowest legal gap, a search over a full store behind
  // stall bursts of both the sender and the receiver.
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_TAIL    = 150;   // last random requests, no stalls
  localparam int SETTLE_WAIT  = 80;    // covers a search over a full store

  // codes the block must treat as no-ops
  localparam logic [2:0] KIND_RSVD_LO = 3'd6;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;

  // request mix of a random phase
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_PROBE} mix_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  deque_tracker tracker = new();

  // stall rates, changed per phase by the stimulus thread
  int tx_gap_pct   = 0;   // chance of a gap before a request
  int rx_stall_pct = 0;   // chance per cycle of a receiver stall burst
  int idle_cycles  = 0;

  double_ended_queue_with_search DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [31:0] value
    .s_tuser  (s_tuser),    // [2:0] kind
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)     // [1:0] status, [2] found, [9:3] count, [10] empty
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: values read here are the ones from before the edge, so a
  // transaction is seen exactly when the block takes it.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) tracker.note_request(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) tracker.check_reply(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: ready by default, dropped for random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Present one request and hold it until the transaction completes.
  // tvalid stays high between back-to-back requests.
  task automatic issue(logic [2:0] op, logic [31:0] key);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
  endtask

  // Values to push: extremes, a small pool so duplicates occur, full range.
  function automatic logic [31:0] payload();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      2, 3: return 32'($urandom_range(0, 11)) - 32'd6;
      default: return $urandom();
    endcase
  endfunction

  // Search keys: mostly held entries (hit anywhere in the list), some
  // one-bit neighbours of held entries (near misses), the rest anything.
  function automatic logic [31:0] search_key();
    int unsigned n;
    int unsigned r;
    logic [31:0] pick;
    n = tracker.entries();
    r = $urandom_range(0, 9);
    if (n == 0 || r >= 8) return payload();
    pick = tracker.entry_at($urandom_range(0, n - 1));
    if (r < 6) return pick;
    return pick ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  task automatic random_item(mix_t mix);
    int          roll;
    int          push_w;
    int          drop_w;
    logic [2:0]  op;
    case (mix)
      MIX_FILL:  begin push_w = 75; drop_w = 10; end
      MIX_DRAIN: begin push_w = 12; drop_w = 73; end
      MIX_EVEN:  begin push_w = 40; drop_w = 35; end
      default:   begin push_w = 30; drop_w = 20; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_w)
      op = $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT;
    else if (roll < push_w + drop_w)
      op = $urandom_range(0, 1) ? deq_pkg::KIND_DROP_BACK : deq_pkg::KIND_DROP_FRONT;
    else if (roll < 97)
      op = deq_pkg::KIND_SEARCH;
    else if (roll < 99 && mix == MIX_EVEN)
      op = deq_pkg::KIND_CLEAR;   // only here, so fill phases reach full
    else if (roll < 99)
      op = deq_pkg::KIND_SEARCH;
    else
      op = $urandom_range(0, 1) ? KIND_RSVD_HI : KIND_RSVD_LO;
    issue(op, (op == deq_pkg::KIND_SEARCH) ? search_key() : payload());
  endtask

  initial begin
    int   sent;
    int   run_len;
    int   k;
    mix_t mix;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list cases and no-op codes first
    issue(deq_pkg::KIND_SEARCH, 32'h0000_0000);       // search on empty list
    issue(deq_pkg::KIND_DROP_FRONT, 32'h1234_5678);   // drop from empty list
    issue(deq_pkg::KIND_DROP_BACK, 32'hFFFF_FFFF);
    issue(KIND_RSVD_LO, 32'hA5A5_5A5A);
    issue(KIND_RSVD_HI, 32'hFFFF_FFFF);
    // value extremes at both ends; first push front wraps the front index
    issue(deq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
    issue(deq_pkg::KIND_PUSH_BACK, 32'h7FFF_FFFF);
    issue(deq_pkg::KIND_PUSH_FRONT, 32'h0000_0000);
    issue(deq_pkg::KIND_PUSH_BACK, 32'hFFFF_FFFF);
    // hits at front, middle and back, then near misses
    issue(deq_pkg::KIND_SEARCH, 32'h0000_0000);
    issue(deq_pkg::KIND_SEARCH, 32'h8000_0000);
    issue(deq_pkg::KIND_SEARCH, 32'hFFFF_FFFF);
    issue(deq_pkg::KIND_SEARCH, 32'h7FFF_FFFE);
    issue(deq_pkg::KIND_SEARCH, 32'h0000_0001);
    issue(KIND_RSVD_LO, 32'h0000_0000);               // no-op with entries held
    issue(deq_pkg::KIND_DROP_FRONT, 32'h0000_0000);
    issue(deq_pkg::KIND_DROP_BACK, 32'h0000_0000);
    issue(deq_pkg::KIND_SEARCH, 32'h0000_0000);       // dropped entry must miss
    issue(deq_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
    issue(deq_pkg::KIND_SEARCH, 32'h8000_0000);       // stale store content, not held
    issue(deq_pkg::KIND_DROP_BACK, 32'h0000_0000);
    issue(deq_pkg::KIND_PUSH_BACK, 32'h0000_0001);
    issue(deq_pkg::KIND_DROP_FRONT, 32'h0000_0000);

    // Random phases; full and empty are reached by the biased mixes
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix     = mix_t'($urandom_range(0, 3));
      run_len = $urandom_range(30, 160);
      case ($urandom_range(0, 2))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 15;
        default: tx_gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_stall_pct = 0;
        1:       rx_stall_pct = 5;
        default: rx_stall_pct = 20;
      endcase
      for (k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        if (RANDOM_ITEMS - sent <= CALM_TAIL) begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
        random_item(mix);
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // one edge so the monitor has logged the last request
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    if (tracker.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
